/* sv/iolfc_pkg.sv */
`default_nettype none

package iolfc_pkg;

    // Running check seed and the length code that marks a bad frame
    localparam logic [7:0] SEED    = 8'h52;
    localparam logic [7:0] LEN_BAD = 8'hFF;

    // Frame status codes reported on the closing result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    // Queue between the parser and the output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // One classified result on its way to the output stage
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic [1:0] channel;
        logic       frame_end;
        logic       length_bad;
        logic [7:0] xor_acc;
        logic [5:0] rx_check;
    } t_item;

    // Fold an 8-bit running XOR down to the 6-bit check value
    function automatic logic [5:0] fold6(input logic [7:0] c);
        logic [5:0] r;
        r[5] = c[7] ^ c[5] ^ c[3] ^ c[1];
        r[4] = c[6] ^ c[4] ^ c[2] ^ c[0];
        r[3] = c[7] ^ c[6];
        r[2] = c[5] ^ c[4];
        r[1] = c[3] ^ c[2];
        r[0] = c[1] ^ c[0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/iolfc_if.sv */
`default_nettype none

interface iolfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface iolfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [1:0] channel;
    logic       frame_end;
    logic [1:0] frame_status;

    modport source (output valid, output payload_byte, output has_byte, output channel,
                    output frame_end, output frame_status, input ready);
    modport sink   (input valid, input payload_byte, input has_byte, input channel,
                    input frame_end, input frame_status, output ready);
endinterface

`default_nettype wire

/* sv/io_link_frame_checker.sv */
// Channel  Dir  Payload                                              Transfer
// i_in     in   byte_in[7:0]                                         valid & ready
// o_out    out  payload_byte[7:0] has_byte channel[1:0] frame_end    valid & ready
//               frame_status[1:0]
//
// One byte per cycle: the parser takes a byte every clock while the two-entry
// result queue has room, and the output stage drains one result per clock while
// o_out.ready is high. A result enters the queue when its byte transfers, moves
// into the output register once that is empty or draining, then transfers on o_out.
// Reset (i_rst_n low, synchronous) returns the parser to waiting for a length byte
// and empties the queue and the output register.
// An output stall backs up into the queue; i_in.ready drops only when the queue is full.
`default_nettype none

module io_link_frame_checker (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    iolfc_in_if.sink    i_in,
    iolfc_out_if.source o_out
);

    logic             push;
    iolfc_pkg::t_item push_item;
    logic             q_full;
    logic             pop;
    iolfc_pkg::t_item pop_item;
    logic             q_empty;

    iolfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    iolfc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_item  (pop_item),
        .o_empty     (q_empty)
    );

    iolfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (pop_item),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

/* sv/iolfc_front.sv */
`default_nettype none

module iolfc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    iolfc_in_if.sink           i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output iolfc_pkg::t_item   o_push_item
);

    localparam logic [1:0] PH_LEN = 2'd0;
    localparam logic [1:0] PH_CHK = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;

    logic [1:0] r_phase,      n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_xor_acc,    n_xor_acc;
    logic [5:0] r_rx_check,   n_rx_check;
    logic [1:0] r_rx_channel, n_rx_channel;
    logic       r_length_bad, n_length_bad;

    logic       accept;
    logic [7:0] b;
    logic [7:0] left_dec;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign b          = i_in.byte_in;
    assign left_dec   = r_bytes_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_xor_acc    = r_xor_acc;
        n_rx_check   = r_rx_check;
        n_rx_channel = r_rx_channel;
        n_length_bad = r_length_bad;
        o_push       = 1'b0;
        o_push_item  = '0;

        if (accept) begin
            unique case (r_phase)
                PH_CHK: begin
                    n_rx_channel = b[7:6];
                    n_rx_check   = b[5:0];
                    n_xor_acc    = iolfc_pkg::SEED ^ {b[7:6], 6'd0};
                    n_bytes_left = left_dec;
                    if (left_dec == '0) begin
                        // length one: the check byte closes the frame
                        n_phase                 = PH_LEN;
                        o_push                  = 1'b1;
                        o_push_item.channel     = b[7:6];
                        o_push_item.frame_end   = 1'b1;
                        o_push_item.length_bad  = r_length_bad;
                        o_push_item.xor_acc     = n_xor_acc;
                        o_push_item.rx_check    = b[5:0];
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
                PH_PAY: begin
                    n_bytes_left = left_dec;
                    if (!r_length_bad) begin
                        n_xor_acc = r_xor_acc ^ b;
                    end
                    o_push_item.channel    = r_rx_channel;
                    o_push_item.length_bad = r_length_bad;
                    o_push_item.xor_acc    = n_xor_acc;
                    o_push_item.rx_check   = r_rx_check;
                    if (left_dec == '0) begin
                        n_phase                  = PH_LEN;
                        o_push                   = 1'b1;
                        o_push_item.frame_end    = 1'b1;
                        o_push_item.has_byte     = !r_length_bad;
                        o_push_item.payload_byte = r_length_bad ? 8'd0 : b;
                    end else if (!r_length_bad) begin
                        o_push                   = 1'b1;
                        o_push_item.has_byte     = 1'b1;
                        o_push_item.payload_byte = b;
                    end
                end
                default: begin
                    // length byte, also taken in the unused phase code
                    n_rx_channel = '0;
                    n_rx_check   = '0;
                    n_xor_acc    = '0;
                    n_bytes_left = b;
                    if (b == '0) begin
                        n_length_bad           = 1'b1;
                        n_phase                = PH_LEN;
                        o_push                 = 1'b1;
                        o_push_item.frame_end  = 1'b1;
                        o_push_item.length_bad = 1'b1;
                    end else begin
                        n_length_bad = (b == iolfc_pkg::LEN_BAD);
                        n_phase      = PH_CHK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_bytes_left <= '0;
            r_xor_acc    <= '0;
            r_rx_check   <= '0;
            r_rx_channel <= '0;
            r_length_bad <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_xor_acc    <= n_xor_acc;
            r_rx_check   <= n_rx_check;
            r_rx_channel <= n_rx_channel;
            r_length_bad <= n_length_bad;
        end
    end

endmodule

`default_nettype wire

/* sv/iolfc_fifo.sv */
`default_nettype none

module iolfc_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire iolfc_pkg::t_item   i_push_item,
    output logic                    o_full,
    input  wire logic               i_pop,
    output iolfc_pkg::t_item        o_pop_item,
    output logic                    o_empty
);

    localparam int AW = iolfc_pkg::QUEUE_AW;
    localparam logic [AW-1:0] PTR_LAST = AW'(iolfc_pkg::QUEUE_DEPTH - 1);
    localparam logic [AW:0]   CNT_FULL = (AW+1)'(iolfc_pkg::QUEUE_DEPTH);

    iolfc_pkg::t_item r_mem [iolfc_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;

    assign o_full     = (r_count == CNT_FULL);
    assign o_empty    = (r_count == '0);
    assign o_pop_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/iolfc_back.sv */
`default_nettype none

module iolfc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire iolfc_pkg::t_item   i_q_item,
    output logic                    o_pop,
    iolfc_out_if.source             o_out
);

    logic       r_valid;
    logic [7:0] r_payload_byte;
    logic       r_has_byte;
    logic [1:0] r_channel;
    logic       r_frame_end;
    logic [1:0] r_frame_status;
    logic [1:0] n_frame_status;
    logic       load;

    // Refill the output register when it is empty or being drained
    assign load  = !i_q_empty && (!r_valid || o_out.ready);
    assign o_pop = load;

    always_comb begin
        priority if (!i_q_item.frame_end) begin
            n_frame_status = iolfc_pkg::ST_OK;
        end else if (i_q_item.length_bad) begin
            n_frame_status = iolfc_pkg::ST_BAD_LEN;
        end else if (iolfc_pkg::fold6(i_q_item.xor_acc) == i_q_item.rx_check) begin
            n_frame_status = iolfc_pkg::ST_OK;
        end else begin
            n_frame_status = iolfc_pkg::ST_MISMATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_payload_byte <= i_q_item.payload_byte;
            r_has_byte     <= i_q_item.has_byte;
            r_channel      <= i_q_item.channel;
            r_frame_end    <= i_q_item.frame_end;
            r_frame_status <= n_frame_status;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.payload_byte = r_payload_byte;
    assign o_out.has_byte     = r_has_byte;
    assign o_out.channel      = r_channel;
    assign o_out.frame_end    = r_frame_end;
    assign o_out.frame_status = r_frame_status;

endmodule

`default_nettype wire

/* sv/iolfc_checker.sv */
`default_nettype none

module iolfc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_payload_byte,
    input wire logic       i_has_byte,
    input wire logic [1:0] i_channel,
    input wire logic       i_frame_end,
    input wire logic [1:0] i_frame_status
);

    // Hold a result until it is taken
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_payload_byte) && $stable(i_has_byte) && $stable(i_channel) &&
             $stable(i_frame_end) && $stable(i_frame_status)))
        else $error("result changed while stalled");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_has_byte) |-> (i_payload_byte == 8'd0))
        else $error("payload byte set without has_byte");

    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_frame_end) |->
            (i_has_byte && i_frame_status == iolfc_pkg::ST_OK))
        else $error("mid-frame result without byte or with status");

    a_bad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_status == iolfc_pkg::ST_BAD_LEN) |->
            (!i_has_byte && i_frame_end))
        else $error("bad length result carries a byte");

endmodule

bind io_link_frame_checker iolfc_checker u_iolfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_payload_byte (o_out.payload_byte),
    .i_has_byte     (o_out.has_byte),
    .i_channel      (o_out.channel),
    .i_frame_end    (o_out.frame_end),
    .i_frame_status (o_out.frame_status)
);

`default_nettype wire
